// ===== hdl/plvs_pkg.sv =====
// Package for the point light vertex shader: payload and configuration types,
// widths, pipeline stage numbering, register map and the channel shading function.
// No dependencies.
`timescale 1ns / 1ps

package plvs_pkg;

    // Field widths.
    localparam int PT_W     = 16;            // pixel coordinate
    localparam int CH_W     = 8;             // one colour channel
    localparam int RAD_W    = 15;            // light radius
    localparam int COLOR_W  = 3 * CH_W;      // packed light colour

    // Squared distance: |dx|^2 + 4*|dy|^2 needs 35 bits, padded to an even count.
    localparam int D2_W       = 2 * PT_W + 4;
    localparam int ROOT_STEPS = D2_W / 2;    // one root bit per stage
    localparam int DIST_W     = ROOT_STEPS;
    localparam int REM_W      = DIST_W + 2;
    localparam int PROD_W     = RAD_W + CH_W;
    localparam int DIV_STEPS  = CH_W;        // quotient never exceeds one channel

    // Pipeline stage numbering.
    localparam int ST_SQ    = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_ROOT0 = 2;
    localparam int ST_MUL   = ST_ROOT0 + ROOT_STEPS;
    localparam int ST_DIV0  = ST_MUL + 1;
    localparam int ST_LAST  = ST_DIV0 + DIV_STEPS - 1;
    localparam int N_ST     = ST_LAST + 1;

    // Register map.
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_LIGHT_X      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_Y      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_RADIUS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_COLOR  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ISOMETRIC    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_ON     = 3'd5;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic [CH_W-1:0]        vertex_red;
        logic [CH_W-1:0]        vertex_green;
        logic [CH_W-1:0]        vertex_blue;
        logic [CH_W-1:0]        base_red;
        logic [CH_W-1:0]        base_green;
        logic [CH_W-1:0]        base_blue;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            inside_light;
    } t_out;

    typedef struct packed {
        logic signed [PT_W-1:0] light_x;
        logic signed [PT_W-1:0] light_y;
        logic [RAD_W-1:0]       light_radius;
        logic [COLOR_W-1:0]     light_color;
        logic                   isometric_mode;
        logic                   light_on;
    } t_cfg;

    // Per-request data that travels alongside the arithmetic.
    typedef struct packed {
        logic [CH_W-1:0] vert_r;
        logic [CH_W-1:0] vert_g;
        logic [CH_W-1:0] vert_b;
        logic [CH_W-1:0] base_r;
        logic [CH_W-1:0] base_g;
        logic [CH_W-1:0] base_b;
        logic            lit;
    } t_side;

    // Light level less the fall-off, floored at zero, then raised to the vertex level.
    function automatic logic [CH_W-1:0] f_shade(input logic [CH_W-1:0] light,
                                                input logic [CH_W-1:0] quot,
                                                input logic [CH_W-1:0] vert);
        logic [CH_W:0]   diff;
        logic [CH_W-1:0] clamped;
        diff    = {1'b0, light} - {1'b0, quot};
        clamped = diff[CH_W] ? '0 : diff[CH_W-1:0];
        return (clamped < vert) ? vert : clamped;
    endfunction

endpackage

// ===== hdl/plvs_dist.sv =====
// Distance pipeline: squared offsets, their weighted sum and a one-bit-per-stage
// integer square root. Depends on plvs_pkg.
`timescale 1ns / 1ps

module plvs_dist (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  plvs_pkg::t_cfg                 i_cfg,
    input  logic signed [plvs_pkg::PT_W-1:0] i_point_x,
    input  logic signed [plvs_pkg::PT_W-1:0] i_point_y,
    output logic [plvs_pkg::DIST_W-1:0]    o_dist
);
    import plvs_pkg::*;

    logic [PT_W:0]       w_dx;
    logic [PT_W:0]       w_dy;
    logic [PT_W-1:0]     w_ux;
    logic [PT_W-1:0]     w_uy;
    logic [2*PT_W-1:0]   r_ux2;
    logic [2*PT_W-1:0]   r_uy2;
    logic [D2_W-2:0]     w_sum;
    logic [D2_W-1:0]     r_d2;

    logic [REM_W-1:0]    r_rem  [ROOT_STEPS];
    logic [DIST_W-1:0]   r_root [ROOT_STEPS];
    logic [D2_W-1:0]     r_bits [ROOT_STEPS];

    // Offsets span 17 bits; their magnitudes fit in 16.
    always_comb begin
        w_dx = {i_cfg.light_x[PT_W-1], i_cfg.light_x} - {i_point_x[PT_W-1], i_point_x};
        w_dy = {i_cfg.light_y[PT_W-1], i_cfg.light_y} - {i_point_y[PT_W-1], i_point_y};
        w_ux = w_dx[PT_W] ? PT_W'(-w_dx) : w_dx[PT_W-1:0];
        w_uy = w_dy[PT_W] ? PT_W'(-w_dy) : w_dy[PT_W-1:0];
        w_sum = {3'b000, r_ux2}
              + (i_cfg.isometric_mode ? {1'b0, r_uy2, 2'b00} : {3'b000, r_uy2});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ux2 <= w_ux * w_ux;
            r_uy2 <= w_uy * w_uy;
            r_d2  <= {1'b0, w_sum};
        end
    end

    genvar j;
    for (j = 0; j < ROOT_STEPS; j++) begin : g_root
        logic [REM_W-1:0]  w_rem_in;
        logic [DIST_W-1:0] w_root_in;
        logic [D2_W-1:0]   w_bits_in;
        logic [REM_W+1:0]  w_shift;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_left;

        if (j == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_bits_in = r_d2;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
            assign w_bits_in = r_bits[j-1];
        end

        always_comb begin
            w_shift = {w_rem_in, w_bits_in[D2_W-1 -: 2]};
            w_trial = {2'b00, w_root_in, 2'b01};
            w_left  = w_shift - w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_shift >= w_trial) begin
                    r_rem[j]  <= w_left[REM_W-1:0];
                    r_root[j] <= {w_root_in[DIST_W-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= w_shift[REM_W-1:0];
                    r_root[j] <= {w_root_in[DIST_W-2:0], 1'b0};
                end
                r_bits[j] <= {w_bits_in[D2_W-3:0], 2'b00};
            end
        end
    end

    assign o_dist = r_root[ROOT_STEPS-1];

endmodule

// ===== hdl/plvs_lane.sv =====
// One colour lane: fall-off product and an eight-stage restoring divider by the radius.
// Depends on plvs_pkg.
`timescale 1ns / 1ps

module plvs_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [plvs_pkg::DIST_W-1:0]   i_dist,
    input  logic [plvs_pkg::CH_W-1:0]     i_light,
    input  logic [plvs_pkg::CH_W-1:0]     i_base,
    input  logic [plvs_pkg::RAD_W-1:0]    i_radius,
    output logic [plvs_pkg::CH_W-1:0]     o_quot
);
    import plvs_pkg::*;

    logic [CH_W-1:0]   w_diff;
    logic [PROD_W-1:0] r_prod;

    logic [RAD_W-1:0]  r_rem [DIV_STEPS];
    logic [CH_W-1:0]   r_lo  [DIV_STEPS];
    logic [CH_W-1:0]   r_q   [DIV_STEPS];

    assign w_diff = (i_light > i_base) ? (i_light - i_base) : (i_base - i_light);

    // Only a lit vertex uses the product, so the distance is below 2^15 there.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_dist[RAD_W-1:0] * w_diff;
        end
    end

    genvar i;
    for (i = 0; i < DIV_STEPS; i++) begin : g_div
        logic [RAD_W-1:0] w_rem_in;
        logic [CH_W-1:0]  w_lo_in;
        logic [CH_W-1:0]  w_q_in;
        logic [RAD_W:0]   w_trial;
        logic [RAD_W:0]   w_left;

        if (i == 0) begin : g_first
            assign w_rem_in = r_prod[PROD_W-1 -: RAD_W];
            assign w_lo_in  = r_prod[CH_W-1:0];
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[i-1];
            assign w_lo_in  = r_lo[i-1];
            assign w_q_in   = r_q[i-1];
        end

        always_comb begin
            w_trial = {w_rem_in, w_lo_in[CH_W-1]};
            w_left  = w_trial - {1'b0, i_radius};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_trial >= {1'b0, i_radius}) begin
                    r_rem[i] <= w_left[RAD_W-1:0];
                    r_q[i]   <= {w_q_in[CH_W-2:0], 1'b1};
                end else begin
                    r_rem[i] <= w_trial[RAD_W-1:0];
                    r_q[i]   <= {w_q_in[CH_W-2:0], 1'b0};
                end
                r_lo[i] <= {w_lo_in[CH_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q[DIV_STEPS-1];

endmodule

// ===== hdl/point_light_vertex_shade.sv =====
// Top level of the point light vertex shader: APB register file, pipeline control,
// three colour lanes and the merging output stage. Depends on plvs_pkg, plvs_dist, plvs_lane.
`timescale 1ns / 1ps

// Each request carries one vertex: its position, its colour and an ambient base
// colour. The block accepts one request per clock while o_in_stall is low and
// returns one result per request, in order; each result is held in the output
// register until it is taken at an edge where the output is not stalled.
// The path runs through the distance pipeline (two stages for the squared
// offsets and their sum, then an 18-stage square root producing one root bit per
// stage) followed by the colour lanes (one multiply stage and an 8-stage
// restoring divider by the radius) and the output register. The whole pipeline
// moves together; when a finished result is held at the output, further
// requests are still taken until the item behind the output register would have
// nowhere to go. Registers should only be written while nothing is in flight.
// A radius of zero behaves as a radius of one.
module point_light_vertex_shade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plvs_pkg::PADDR_W-1:0]  paddr,
    input  logic [plvs_pkg::APB_W-1:0]    pwdata,
    output logic [plvs_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  plvs_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output plvs_pkg::t_out                o_out_data
);
    import plvs_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic [RAD_W-1:0]     w_radius;

    logic                 w_adv;
    logic                 w_in_acc;
    logic [N_ST-1:0]      r_vld;
    t_side                r_side [N_ST];
    t_side                w_side_mul;
    logic                 r_out_vld;
    t_out                 r_out;

    logic [DIST_W-1:0]    w_dist;
    logic                 w_inside;
    logic [CH_W-1:0]      w_q_r;
    logic [CH_W-1:0]      w_q_g;
    logic [CH_W-1:0]      w_q_b;
    t_out                 n_out;

    // ------------------------------------------------------------------
    // Register file. Writes complete in the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_x        <= '0;
            r_cfg.light_y        <= '0;
            r_cfg.light_radius   <= RAD_W'(1);
            r_cfg.light_color    <= '1;
            r_cfg.isometric_mode <= 1'b0;
            r_cfg.light_on       <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_LIGHT_X:      r_cfg.light_x        <= pwdata[PT_W-1:0];
                REG_LIGHT_Y:      r_cfg.light_y        <= pwdata[PT_W-1:0];
                REG_LIGHT_RADIUS: r_cfg.light_radius   <= pwdata[RAD_W-1:0];
                REG_LIGHT_COLOR:  r_cfg.light_color    <= pwdata[COLOR_W-1:0];
                REG_ISOMETRIC:    r_cfg.isometric_mode <= pwdata[0];
                REG_LIGHT_ON:     r_cfg.light_on       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LIGHT_X:      prdata = {{(APB_W-PT_W){1'b0}}, r_cfg.light_x};
            REG_LIGHT_Y:      prdata = {{(APB_W-PT_W){1'b0}}, r_cfg.light_y};
            REG_LIGHT_RADIUS: prdata = {{(APB_W-RAD_W){1'b0}}, r_cfg.light_radius};
            REG_LIGHT_COLOR:  prdata = {{(APB_W-COLOR_W){1'b0}}, r_cfg.light_color};
            REG_ISOMETRIC:    prdata = {{(APB_W-1){1'b0}}, r_cfg.isometric_mode};
            REG_LIGHT_ON:     prdata = {{(APB_W-1){1'b0}}, r_cfg.light_on};
            default:          prdata = '0;
        endcase
    end

    // A zero radius is treated as one, so the divider never sees zero.
    assign w_radius = (r_cfg.light_radius == '0) ? RAD_W'(1) : r_cfg.light_radius;

    // ------------------------------------------------------------------
    // Pipeline control. All stages advance together unless the last stage holds
    // a result and the output register is occupied and stalled.
    // ------------------------------------------------------------------
    assign w_adv      = !(r_out_vld && i_out_stall && r_vld[ST_LAST]);
    assign o_in_stall = !w_adv;
    assign w_in_acc   = i_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[N_ST-2:0], w_in_acc};
            end
            if (w_adv && r_vld[ST_LAST]) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Distance pipeline and the lit test, which is made once the root is known.
    // ------------------------------------------------------------------
    plvs_dist u_dist (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_cfg     (r_cfg),
        .i_point_x (i_in_data.point_x),
        .i_point_y (i_in_data.point_y),
        .o_dist    (w_dist)
    );

    assign w_inside = r_cfg.light_on && (w_dist <= {{(DIST_W-RAD_W){1'b0}}, w_radius});

    // The entry into the multiply stage picks up the lit flag.
    always_comb begin
        w_side_mul     = r_side[ST_MUL-1];
        w_side_mul.lit = w_inside;
    end

    // Colours and the lit flag ride alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[ST_SQ].vert_r <= i_in_data.vertex_red;
            r_side[ST_SQ].vert_g <= i_in_data.vertex_green;
            r_side[ST_SQ].vert_b <= i_in_data.vertex_blue;
            r_side[ST_SQ].base_r <= i_in_data.base_red;
            r_side[ST_SQ].base_g <= i_in_data.base_green;
            r_side[ST_SQ].base_b <= i_in_data.base_blue;
            r_side[ST_SQ].lit    <= 1'b0;
            for (int k = 1; k < N_ST; k++) begin
                r_side[k] <= (k == ST_MUL) ? w_side_mul : r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Colour lanes: red, green and blue each compute their own fall-off.
    // ------------------------------------------------------------------
    plvs_lane u_lane_r (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_dist   (w_dist),
        .i_light  (r_cfg.light_color[3*CH_W-1 -: CH_W]),
        .i_base   (r_side[ST_MUL-1].base_r),
        .i_radius (w_radius),
        .o_quot   (w_q_r)
    );

    plvs_lane u_lane_g (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_dist   (w_dist),
        .i_light  (r_cfg.light_color[2*CH_W-1 -: CH_W]),
        .i_base   (r_side[ST_MUL-1].base_g),
        .i_radius (w_radius),
        .o_quot   (w_q_g)
    );

    plvs_lane u_lane_b (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_dist   (w_dist),
        .i_light  (r_cfg.light_color[CH_W-1:0]),
        .i_base   (r_side[ST_MUL-1].base_b),
        .i_radius (w_radius),
        .o_quot   (w_q_b)
    );

    // ------------------------------------------------------------------
    // Merging stage: a lit vertex takes the shaded lanes, otherwise the base colour.
    // ------------------------------------------------------------------
    always_comb begin
        n_out.inside_light = r_side[ST_LAST].lit;
        if (r_side[ST_LAST].lit) begin
            n_out.out_red   = f_shade(r_cfg.light_color[3*CH_W-1 -: CH_W], w_q_r,
                                      r_side[ST_LAST].vert_r);
            n_out.out_green = f_shade(r_cfg.light_color[2*CH_W-1 -: CH_W], w_q_g,
                                      r_side[ST_LAST].vert_g);
            n_out.out_blue  = f_shade(r_cfg.light_color[CH_W-1:0], w_q_b,
                                      r_side[ST_LAST].vert_b);
        end else begin
            n_out.out_red   = r_side[ST_LAST].base_r;
            n_out.out_green = r_side[ST_LAST].base_g;
            n_out.out_blue  = r_side[ST_LAST].base_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_vld[ST_LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A finished item leaving the last stage always lands in the output register.
    a_last_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_LAST] && !o_in_stall |=> o_out_valid)
        else $error("result from the last stage was not delivered to the output");

    // New requests are held off only while the output is full and blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked output");

    // A lit result can only come from an active light.
    a_lit_needs_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.inside_light |-> r_cfg.light_on)
        else $error("lit result reported while the light is off");
`endif

endmodule

// ===== tb/point_light_vertex_shade_tb.sv =====
// Self-checking testbench for the point light vertex shader: directed and random vertex
// requests with randomised handshake idling, checked against a behavioural shading model
// or typed results. Depends on plvs_pkg and point_light_vertex_shade.
`timescale 1ns / 1ps

module point_light_vertex_shade_tb;

    import plvs_pkg::*;

    // Two register slots past the end of the map; writes there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int MAX_GAP        = 16;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, well past the pipe depth
    localparam int DRAIN_CYCLES   = 40;    // longer than a request takes to pass the pipeline
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 130;
    localparam int PRESSURE_PHASE = 2;
    localparam int DARK_PHASE     = 4;

    localparam t_cfg CFG_AT_RESET = '{
        light_x:        16'sd0,
        light_y:        16'sd0,
        light_radius:   15'd1,
        light_color:    24'hFFFFFF,
        isometric_mode: 1'b0,
        light_on:       1'b1
    };

    // One row of the directed plan: the register setting it runs under, the request,
    // and, where the answer is obvious, the result typed in by hand.
    typedef struct {
        t_cfg cfg;
        t_in  req;
        bit   typed;
        t_out res;
    } t_plan_row;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [APB_W-1:0]     pwdata      = '0;
    logic [APB_W-1:0]     prdata;
    logic                 pready;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b1;
    t_out                 o_out_data;

    // Shadow of the register file, updated as each write lands.
    t_cfg                 light_cfg = CFG_AT_RESET;
    t_out                 pending_shades[$];
    t_plan_row            plan[$];

    // Idling controls set by the stimulus for the request driver and the result sink.
    bit                   idle_in  = 1'b1;
    bit                   idle_out = 1'b1;
    bit                   hold_req = 1'b0;

    int                   fail_count    = 0;
    int                   sent_count    = 0;
    int                   checked_count = 0;
    int                   write_count   = 0;
    int                   quiet_cycles  = 0;
    int                   backpressure_cycles = 0;

    point_light_vertex_shade u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shading model
    // ------------------------------------------------------------------------

    // Largest root whose square does not exceed n, built one bit at a time from the top.
    // The squared distance never reaches 2^36, so 18 root bits suffice.
    function automatic longint root_floor(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // One colour channel inside the light: the light level falls off linearly with
    // distance by up to the light-base difference, goes no lower than zero, and is then lifted
    // to the vertex level if that is brighter.
    function automatic logic [CH_W-1:0] lit_level(input logic [CH_W-1:0] light,
                                                  input logic [CH_W-1:0] base,
                                                  input logic [CH_W-1:0] vert,
                                                  input longint dist_px,
                                                  input longint reach);
        longint spread;
        longint level;
        spread = (light > base) ? longint'(light) - longint'(base)
                                : longint'(base) - longint'(light);
        level  = longint'(light) - (dist_px * spread) / reach;
        if (level < 0)
            level = 0;
        if (level < longint'(vert))
            level = longint'(vert);
        return level[CH_W-1:0];
    endfunction

    function automatic t_out shade_vertex(input t_cfg c, input t_in r);
        t_out   res;
        longint dx;
        longint dy;
        longint dist_px;
        longint reach;
        res = '{out_red: r.base_red, out_green: r.base_green, out_blue: r.base_blue,
                inside_light: 1'b0};
        if (c.light_on) begin
            dx = longint'($signed(c.light_x)) - longint'($signed(r.point_x));
            dy = longint'($signed(c.light_y)) - longint'($signed(r.point_y));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            // The isometric view doubles the weight of the vertical offset.
            dist_px = root_floor(dx * dx + (c.isometric_mode ? 4 : 1) * dy * dy);
            reach   = (c.light_radius == 0) ? 1 : longint'(c.light_radius);
            if (dist_px <= reach) begin
                res.out_red   = lit_level(c.light_color[23:16], r.base_red,
                                          r.vertex_red, dist_px, reach);
                res.out_green = lit_level(c.light_color[15:8], r.base_green,
                                          r.vertex_green, dist_px, reach);
                res.out_blue  = lit_level(c.light_color[7:0], r.base_blue,
                                          r.vertex_blue, dist_px, reach);
                res.inside_light = 1'b1;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Register and request drivers
    // ------------------------------------------------------------------------

    // One APB write: a setup phase, then an access phase held until pready. psel is
    // left high so that writes can follow back to back; the caller lowers it.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_W-1:0] data);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        write_count++;
        case (idx)
            REG_LIGHT_X:      light_cfg.light_x        = data[15:0];
            REG_LIGHT_Y:      light_cfg.light_y        = data[15:0];
            REG_LIGHT_RADIUS: light_cfg.light_radius   = data[RAD_W-1:0];
            REG_LIGHT_COLOR:  light_cfg.light_color    = data[COLOR_W-1:0];
            REG_ISOMETRIC:    light_cfg.isometric_mode = data[0];
            REG_LIGHT_ON:     light_cfg.light_on       = data[0];
            default: ;
        endcase
    endtask

    // Writes the whole register set. With junk set, the unused upper data bits carry
    // random values and the two slots past the map are written too.
    task automatic program_lighting(input t_cfg c, input bit junk);
        logic [APB_W-1:0] pad;
        pad = junk ? $urandom() : '0;
        reg_write(REG_LIGHT_X,      (pad & 32'hFFFF_0000) | {16'h0, c.light_x});
        pad = junk ? $urandom() : '0;
        reg_write(REG_LIGHT_Y,      (pad & 32'hFFFF_0000) | {16'h0, c.light_y});
        pad = junk ? $urandom() : '0;
        reg_write(REG_LIGHT_RADIUS, (pad & 32'hFFFF_8000) | {17'h0, c.light_radius});
        pad = junk ? $urandom() : '0;
        reg_write(REG_LIGHT_COLOR,  (pad & 32'hFF00_0000) | {8'h0, c.light_color});
        pad = junk ? $urandom() : '0;
        reg_write(REG_ISOMETRIC,    (pad & 32'hFFFF_FFFE) | {31'h0, c.isometric_mode});
        pad = junk ? $urandom() : '0;
        reg_write(REG_LIGHT_ON,     (pad & 32'hFFFF_FFFE) | {31'h0, c.light_on});
        if (junk) begin
            reg_write(REG_SPARE_LO, $urandom());
            reg_write(REG_SPARE_HI, $urandom());
        end
        psel <= 1'b0;
    endtask

    // Offers one request, holding it steady until the block takes it, and files the
    // expected shade. valid is only lowered when a gap is actually drawn, so a
    // back-to-back request never sees valid dropped and raised in the same step.
    task automatic send_req(input t_in req, input bit typed, input t_out want);
        int gap;
        gap = idle_in ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_shades.push_back(typed ? want : shade_vertex(light_cfg, req));
        sent_count++;
    endtask

    // Called in the step of the last acceptance: drops valid and waits for the pipe
    // to hand back everything it owes. Every request yields a result, so an empty
    // queue means the block is idle.
    task automatic drain_pipe;
        i_in_valid <= 1'b0;
        while (pending_shades.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_row(input t_cfg c,
                                    input logic signed [PT_W-1:0] px,
                                    input logic signed [PT_W-1:0] py,
                                    input logic [COLOR_W-1:0] vert,
                                    input logic [COLOR_W-1:0] base,
                                    input bit typed,
                                    input logic [COLOR_W-1:0] rgb,
                                    input bit lit);
        t_plan_row row;
        row.cfg   = c;
        row.req   = {px, py, vert, base};
        row.typed = typed;
        row.res   = {rgb, lit};
        plan.push_back(row);
    endfunction

    function automatic logic signed [PT_W-1:0] clamp_coord(input int v);
        if (v > 32767)  return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[PT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Result sink: random stall per result, plus one long hold-off on request.
    // ------------------------------------------------------------------------

    initial begin : result_sink
        int   gap;
        t_out want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // Keep the output blocked long enough for the whole pipe to back up.
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = idle_out ? $urandom_range(0, MAX_GAP) : 0;
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);

            checked_count++;
            if (pending_shades.size() == 0) begin
                $error("result with no request outstanding: %p", o_out_data);
                fail_count++;
            end else begin
                want = pending_shades.pop_front();
                if (o_out_data.out_red !== want.out_red) begin
                    $error("out_red: expected %0d, got %0d", want.out_red,
                           o_out_data.out_red);
                    fail_count++;
                end
                if (o_out_data.out_green !== want.out_green) begin
                    $error("out_green: expected %0d, got %0d", want.out_green,
                           o_out_data.out_green);
                    fail_count++;
                end
                if (o_out_data.out_blue !== want.out_blue) begin
                    $error("out_blue: expected %0d, got %0d", want.out_blue,
                           o_out_data.out_blue);
                    fail_count++;
                end
                if (o_out_data.inside_light !== want.inside_light) begin
                    $error("inside_light: expected %0d, got %0d", want.inside_light,
                           o_out_data.inside_light);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel or the register port counts as
    // progress. A long run of cycles with none means the block has hung.
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_stall)
            backpressure_cycles <= backpressure_cycles + 1;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin : stimulus
        t_cfg                  c;
        t_cfg                  nc;
        t_in                   req;
        logic signed [PT_W-1:0] px;
        logic signed [PT_W-1:0] py;
        logic [CH_W-1:0]       vr, vg, vb, br, bg, bb;
        int                    span;
        int                    reach;
        int                    directed_count;

        // Directed plan. Under the reset setting the light sits at the origin with a
        // radius of one and full white.
        c = CFG_AT_RESET;
        add_row(c, 0, 0, 24'h000000, 24'h000000, 1, 24'hFFFFFF, 1);
        // At the rim the fall-off takes the whole channel, so the vertex level wins.
        add_row(c, 1, 0, 24'h8000FF, 24'h000000, 1, 24'h8000FF, 1);
        add_row(c, 2, 0, 24'h000000, 24'h0C2238, 1, 24'h0C2238, 0);
        add_row(c, 0, -1, 24'h123456, 24'h654321, 0, '0, 0);

        // Light switched off: the base colour always comes back.
        c.light_on = 1'b0;
        add_row(c, 0, 0, 24'hFFFFFF, 24'h0A0B0C, 1, 24'h0A0B0C, 0);

        // A radius of zero must act as a radius of one.
        c.light_on     = 1'b1;
        c.light_radius = 15'd0;
        add_row(c, 1, 0, 24'h000000, 24'h000000, 1, 24'h000000, 1);
        add_row(c, 0, 1, 24'h000000, 24'h808080, 1, 24'h808080, 1);
        add_row(c, 1, 1, 24'h000000, 24'h000000, 0, '0, 0);

        // Base brighter than the light: the level would go negative and is floored.
        c.light_radius = 15'd10;
        c.light_color  = 24'h102030;
        add_row(c, 10, 0, 24'h050007, 24'hFFFFFF, 1, 24'h050007, 1);
        add_row(c, 5, 0, 24'h000000, 24'hFF0000, 0, '0, 0);

        // Isometric distance: the vertical offset counts double.
        c.isometric_mode = 1'b1;
        add_row(c, 0, 5, 24'h000000, 24'h000000, 0, '0, 0);
        add_row(c, 0, 6, 24'h000000, 24'h334455, 1, 24'h334455, 0);
        add_row(c, 6, 4, 24'h203040, 24'h000000, 0, '0, 0);

        // Truncated distance: sqrt(32) rounds down onto the rim, sqrt(41) does not.
        c.isometric_mode = 1'b0;
        c.light_radius   = 15'd5;
        add_row(c, 4, 4, 24'h000000, 24'h7F7F7F, 0, '0, 0);
        add_row(c, 4, 5, 24'h000000, 24'h010203, 1, 24'h010203, 0);

        // Coordinate and radius extremes.
        c = '{light_x: 16'sh8000, light_y: 16'sh8000, light_radius: 15'h7FFF,
              light_color: 24'hA0B0C0, isometric_mode: 1'b1, light_on: 1'b1};
        add_row(c, 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF, 24'h010203, 1, 24'h010203, 0);
        add_row(c, 16'sh8000, 16'sh8000, 24'hFF0000, 24'h000000, 1, 24'hFFB0C0, 1);
        add_row(c, 0, 16'sh8000, 24'h000000, 24'h0F0F0F, 1, 24'h0F0F0F, 0);
        add_row(c, -1, 16'sh8000, 24'h000000, 24'h000000, 1, 24'h000000, 1);

        c = '{light_x: 16'sh7FFF, light_y: 16'sh7FFF, light_radius: 15'h7FFF,
              light_color: 24'h000000, isometric_mode: 1'b0, light_on: 1'b1};
        add_row(c, 16'sh8000, 16'sh8000, 24'h000000, 24'hFFFFFF, 1, 24'hFFFFFF, 0);
        add_row(c, 16'sh7FFF, 16'sh7FFF, 24'h7F7F7F, 24'hFFFFFF, 1, 24'h7F7F7F, 1);
        add_row(c, 30000, 30000, 24'hAA55AA, 24'h55AA55, 0, '0, 0);
        directed_count = plan.size();

        // Hold the synchronous reset, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].cfg != light_cfg) begin
                drain_pipe();
                program_lighting(plan[k].cfg, 1'b0);
            end
            send_req(plan[k].req, plan[k].typed, plan[k].res);
        end

        // Random phases, each under a fresh setting written while the pipe is empty.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipe();

            case ($urandom_range(0, 3))
                0:       nc.light_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                1:       nc.light_x = 16'($urandom_range(0, 400) - 200);
                default: nc.light_x = 16'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       nc.light_y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                1:       nc.light_y = 16'($urandom_range(0, 400) - 200);
                default: nc.light_y = 16'($urandom());
            endcase
            case ($urandom_range(0, 5))
                0:       nc.light_radius = 15'd0;
                1:       nc.light_radius = 15'd1;
                2:       nc.light_radius = 15'h7FFF;
                3:       nc.light_radius = 15'($urandom_range(1, 16));
                4:       nc.light_radius = 15'($urandom_range(1, 300));
                default: nc.light_radius = 15'($urandom_range(1, 5000));
            endcase
            case ($urandom_range(0, 5))
                0:       nc.light_color = 24'h000000;
                1:       nc.light_color = 24'hFFFFFF;
                default: nc.light_color = 24'($urandom());
            endcase
            nc.isometric_mode = 1'($urandom_range(0, 1));
            nc.light_on       = (p != DARK_PHASE);
            program_lighting(nc, 1'b1);

            // Rotate through idling patterns: none, sender only, receiver only, both.
            idle_in  = (p % 4 == 1) || (p % 4 == 3);
            idle_out = (p % 4 == 2) || (p % 4 == 3);
            // In the pressure phase the receiver blocks for a long stretch while the
            // sender keeps streaming, so the block has to stall its input.
            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;

            reach = (light_cfg.light_radius == 0) ? 1 : int'(light_cfg.light_radius);
            span  = reach + reach / 4 + 2;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Most vertices land around the light so the shading path is exercised;
                // the rest are anywhere in the coordinate range.
                if ($urandom_range(0, 3) != 0) begin
                    px = clamp_coord(int'($signed(light_cfg.light_x)) +
                                     int'($urandom_range(0, 2 * span)) - span);
                    py = clamp_coord(int'($signed(light_cfg.light_y)) +
                                     int'($urandom_range(0, 2 * span)) - span);
                end else begin
                    px = 16'($urandom());
                    py = 16'($urandom());
                end
                // Vertex levels lean dark so the floor only takes over part of the time.
                vr = 8'($urandom_range(0, 255) >> $urandom_range(0, 8));
                vg = 8'($urandom_range(0, 255) >> $urandom_range(0, 8));
                vb = 8'($urandom_range(0, 255) >> $urandom_range(0, 8));
                br = 8'($urandom_range(0, 255));
                bg = 8'($urandom_range(0, 255));
                bb = 8'($urandom_range(0, 255));
                req = {px, py, vr, vg, vb, br, bg, bb};
                send_req(req, 1'b0, '0);
            end
        end

        drain_pipe();
        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (%0d directed) and %0d results over %0d settings,",
                 sent_count, directed_count, checked_count, NUM_PHASES);
        $display("with %0d register writes and %0d cycles of input back-pressure.",
                 write_count, backpressure_cycles);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
